// File: rtl/cnsp_pkg.sv
// Shared types, constants and lookup functions for the cpio newc stream parser.
`default_nettype none

package cnsp_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_HEADER  = 3'd1,
        PH_NAME    = 3'd2,
        PH_NAMEPAD = 3'd3,
        PH_DATA    = 3'd4,
        PH_DATAPAD = 3'd5,
        PH_TRAILER = 3'd6,
        PH_ERROR   = 3'd7
    } phase_t;

    // Byte classes reported with each byte
    localparam logic [2:0] CLS_MAGIC   = 3'd0;
    localparam logic [2:0] CLS_HDR     = 3'd1;
    localparam logic [2:0] CLS_NAME    = 3'd2;
    localparam logic [2:0] CLS_NAMEPAD = 3'd3;
    localparam logic [2:0] CLS_DATA    = 3'd4;
    localparam logic [2:0] CLS_DATAPAD = 3'd5;
    localparam logic [2:0] CLS_TRAILER = 3'd6;
    localparam logic [2:0] CLS_ERROR   = 3'd7;

    // Held error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MAGIC     = 2'd1;
    localparam logic [1:0] ERR_NAME_ZERO = 2'd2;

    // Header field indexes that change parser state
    localparam logic [3:0] FLD_MODE     = 4'd1;
    localparam logic [3:0] FLD_FILESIZE = 4'd6;
    localparam logic [3:0] FLD_NAMESIZE = 4'd11;

    localparam logic [6:0] MAGIC_LEN   = 7'd6;
    localparam logic [6:0] HDR_LEN     = 7'd110;
    localparam logic [3:0] TRAIL_SIZE  = 4'd11;
    localparam logic [3:0] TRAIL_CMP   = 4'd10;
    localparam logic [3:0] MODE_SYMLNK = 4'hA;

    // One result transaction
    typedef struct packed {
        logic [7:0]  byte_value;
        logic [2:0]  byte_class;
        logic        field_valid;
        logic [3:0]  field_index;
        logic [31:0] field_value;
        logic        last_name_byte;
        logic        last_data_byte;
        logic        is_symlink;
        logic        trailer_reached;
        logic [1:0]  error_code;
    } result_t;

    // Expected magic character at a header position
    function automatic logic [7:0] magic_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = "0";
            3'd1:    c = "7";
            3'd2:    c = "0";
            3'd3:    c = "7";
            3'd4:    c = "0";
            3'd5:    c = "1";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // Trailer name character at a name position
    function automatic logic [7:0] trailer_char(input logic [3:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = "T";
            4'd1:    c = "R";
            4'd2:    c = "A";
            4'd3:    c = "I";
            4'd4:    c = "L";
            4'd5:    c = "E";
            4'd6:    c = "R";
            4'd7:    c = "!";
            4'd8:    c = "!";
            4'd9:    c = "!";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // Hex digit value, upper and lower case; other bytes wrap to 4 bits
    function automatic logic [3:0] hex_nibble(input logic [7:0] b);
        logic [7:0] d;
        if (b >= 8'h61) begin
            d = b - 8'h57;
        end else if (b >= 8'h41) begin
            d = b - 8'h37;
        end else begin
            d = b - 8'h30;
        end
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/cnsp_core.sv
// Parser state registers and the per-byte next-state and result logic.
`default_nettype none

module cnsp_core
    import cnsp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] in_byte,
    output result_t         res
);

    phase_t      phase_reg, phase_next;
    logic [6:0]  hpos_reg, hpos_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] name_rem_reg, name_rem_next;
    logic [31:0] data_rem_reg, data_rem_next;
    logic [1:0]  pad_reg, pad_next;
    logic        sym_reg, sym_next;
    logic        tmatch_reg, tmatch_next;
    logic [1:0]  err_reg, err_next;

    // State registers, advanced once per processed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_MAGIC;
            hpos_reg     <= '0;
            acc_reg      <= '0;
            name_rem_reg <= '0;
            data_rem_reg <= '0;
            pad_reg      <= '0;
            sym_reg      <= 1'b0;
            tmatch_reg   <= 1'b0;
            err_reg      <= ERR_NONE;
        end else if (step) begin
            phase_reg    <= phase_next;
            hpos_reg     <= hpos_next;
            acc_reg      <= acc_next;
            name_rem_reg <= name_rem_next;
            data_rem_reg <= data_rem_next;
            pad_reg      <= pad_next;
            sym_reg      <= sym_next;
            tmatch_reg   <= tmatch_next;
            err_reg      <= err_next;
        end
    end

    // Next state and result for the byte at the input register
    always_comb begin
        logic [6:0] hinc;
        logic [6:0] k;
        logic [3:0] tidx;
        logic [1:0] dpad;

        phase_next    = phase_reg;
        hpos_next     = hpos_reg;
        acc_next      = acc_reg;
        name_rem_next = name_rem_reg;
        data_rem_next = data_rem_reg;
        pad_next      = pad_reg;
        sym_next      = sym_reg;
        tmatch_next   = tmatch_reg;
        err_next      = err_reg;

        hinc = hpos_reg + 7'd1;
        k    = hinc - MAGIC_LEN;
        tidx = TRAIL_SIZE - name_rem_reg[3:0];
        dpad = 2'd0 - data_rem_reg[1:0];

        res                 = '0;
        res.byte_value      = in_byte;
        res.byte_class      = CLS_ERROR;

        unique case (phase_reg)
            PH_MAGIC: begin
                if (in_byte != magic_char(hpos_reg[2:0])) begin
                    err_next   = ERR_MAGIC;
                    phase_next = PH_ERROR;
                end else begin
                    // first magic byte opens a new entry
                    if (hpos_reg == '0) begin
                        sym_next    = 1'b0;
                        tmatch_next = 1'b0;
                    end
                    res.byte_class = CLS_MAGIC;
                    hpos_next      = hinc;
                    if (hinc >= MAGIC_LEN) begin
                        phase_next = PH_HEADER;
                    end
                end
            end
            PH_HEADER: begin
                res.byte_class = CLS_HDR;
                acc_next       = {acc_reg[27:0], hex_nibble(in_byte)};
                hpos_next      = hinc;
                // every eighth digit completes a field
                if (k[2:0] == 3'd0) begin
                    res.field_valid = 1'b1;
                    res.field_index = k[6:3] - 4'd1;
                    res.field_value = acc_next;
                    if (res.field_index == FLD_MODE) begin
                        sym_next = (acc_next[15:12] == MODE_SYMLNK);
                    end else if (res.field_index == FLD_FILESIZE) begin
                        data_rem_next = acc_next;
                    end else if (res.field_index == FLD_NAMESIZE) begin
                        name_rem_next = acc_next;
                        pad_next      = 2'd2 - acc_next[1:0];
                        tmatch_next   = (acc_next == {28'd0, TRAIL_SIZE});
                    end
                end
                if (hinc >= HDR_LEN) begin
                    if (name_rem_next == '0) begin
                        err_next       = ERR_NAME_ZERO;
                        phase_next     = PH_ERROR;
                        res.byte_class = CLS_ERROR;
                    end else begin
                        phase_next = PH_NAME;
                    end
                end
            end
            PH_NAME: begin
                res.byte_class = CLS_NAME;
                if (tmatch_reg && tidx < TRAIL_CMP && in_byte != trailer_char(tidx)) begin
                    tmatch_next = 1'b0;
                end
                name_rem_next = name_rem_reg - 32'd1;
                if (name_rem_next == '0) begin
                    res.last_name_byte = 1'b1;
                    if (tmatch_next) begin
                        phase_next          = PH_TRAILER;
                        res.trailer_reached = 1'b1;
                    end else if (pad_reg != 2'd0) begin
                        phase_next = PH_NAMEPAD;
                    end else begin
                        pad_next = dpad;
                        if (data_rem_reg != '0) begin
                            phase_next = PH_DATA;
                        end else if (dpad != 2'd0) begin
                            phase_next = PH_DATAPAD;
                        end else begin
                            phase_next = PH_MAGIC;
                            hpos_next  = '0;
                        end
                    end
                end
            end
            PH_NAMEPAD: begin
                res.byte_class = CLS_NAMEPAD;
                pad_next       = pad_reg - 2'd1;
                if (pad_next == 2'd0) begin
                    pad_next = dpad;
                    if (data_rem_reg != '0) begin
                        phase_next = PH_DATA;
                    end else if (dpad != 2'd0) begin
                        phase_next = PH_DATAPAD;
                    end else begin
                        phase_next = PH_MAGIC;
                        hpos_next  = '0;
                    end
                end
            end
            PH_DATA: begin
                res.byte_class = CLS_DATA;
                data_rem_next  = data_rem_reg - 32'd1;
                if (data_rem_next == '0) begin
                    res.last_data_byte = 1'b1;
                    if (pad_reg != 2'd0) begin
                        phase_next = PH_DATAPAD;
                    end else begin
                        phase_next = PH_MAGIC;
                        hpos_next  = '0;
                    end
                end
            end
            PH_DATAPAD: begin
                res.byte_class = CLS_DATAPAD;
                pad_next       = pad_reg - 2'd1;
                if (pad_next == 2'd0) begin
                    phase_next = PH_MAGIC;
                    hpos_next  = '0;
                end
            end
            PH_TRAILER: begin
                res.byte_class      = CLS_TRAILER;
                res.trailer_reached = 1'b1;
            end
            PH_ERROR: begin
                res.byte_class = CLS_ERROR;
            end
        endcase

        res.is_symlink = sym_next;
        res.error_code = err_next;
    end

endmodule

`default_nettype wire

// File: rtl/cpio_newc_stream_parser.sv
// An accepted s_ byte goes through the input register, then the result register, to m_.
// Throughput: one byte per cycle unless m_ stalls; cnsp_core updates its state once per byte.
// Backpressure on m_ stalls both stages; s_tready stays high while the result register drains.
// Reset (aresetn low, synchronous) empties both stages and returns the parser to the magic
// phase with all counters, flags and the held error cleared.
`default_nettype none

module cpio_newc_stream_parser
    import cnsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [55:0] m_tdata,   // byte_value, field_valid, field_index, field_value,
                                        // last_name_byte, is_symlink, trailer_reached,
                                        // error_code, zero fill
    output      logic [2:0]  m_tuser,   // [2:0] byte_class
    output      logic        m_tlast    // last_data_byte
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    res_reg;
    result_t    res;
    logic       move;
    logic       s_accept;

    // Input stage advances when the result register is free or being taken
    assign move     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (move ? 1'b0 : in_valid_reg);
        out_valid_next = move ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
        end
        if (move) begin
            res_reg <= res;
        end
    end

    cnsp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (move),
        .in_byte (in_byte_reg),
        .res     (res)
    );

    // Result transaction packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.byte_class;
    assign m_tlast  = res_reg.last_data_byte;
    assign m_tdata  = {6'd0,
                       res_reg.error_code,
                       res_reg.trailer_reached,
                       res_reg.is_symlink,
                       res_reg.last_name_byte,
                       res_reg.field_value,
                       res_reg.field_index,
                       res_reg.field_valid,
                       res_reg.byte_value};

endmodule

`default_nettype wire
